// File: design/tcw_pkg.sv
// Package for the text console writer: field widths, op and control codes,
// config register indexes and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

    // Fixed payload widths
    localparam int OP_W      = 2;
    localparam int CHAR_W    = 8;
    localparam int IDX_W     = 11;
    localparam int COL_OUT_W = 7;
    localparam int ROW_OUT_W = 5;
    localparam int POS_OUT_W = 11;
    localparam int CELL_W    = 16;
    localparam int COLOR_W   = 4;
    localparam int ATTR_W    = 8;

    // Config port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = COLOR_W;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 1'd1;
    localparam logic [COLOR_W-1:0]   FG_RESET     = 4'd11;
    localparam logic [COLOR_W-1:0]   BG_RESET     = 4'd0;

    // Ops
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Control bytes
    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

    localparam logic [CELL_W-1:0] RESET_BLANK = 16'h0B20;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_PUT,
        ST_SCROLL,
        ST_FILL,
        ST_DONE
    } state_t;

endpackage

// File: design/tcw_cmd_if.sv
// Command channel of the text console writer (op, character, cell index).
// Depends on tcw_pkg for field widths.
`timescale 1ns / 1ps

interface tcw_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [tcw_pkg::OP_W-1:0]     op;
    logic [tcw_pkg::CHAR_W-1:0]   char_code;
    logic [tcw_pkg::IDX_W-1:0]    cell_index;

    modport source (output valid, output op, output char_code, output cell_index,
                    input ready);
    modport sink   (input valid, input op, input char_code, input cell_index,
                    output ready);
endinterface

// File: design/tcw_rsp_if.sv
// Response channel of the text console writer (cursor, cell data, scroll flag).
// Depends on tcw_pkg for field widths.
`timescale 1ns / 1ps

interface tcw_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [tcw_pkg::COL_OUT_W-1:0]  cursor_col;
    logic [tcw_pkg::ROW_OUT_W-1:0]  cursor_row;
    logic [tcw_pkg::POS_OUT_W-1:0]  cursor_pos;
    logic [tcw_pkg::CELL_W-1:0]     cell_data;
    logic                           scrolled;

    modport source (output valid, output cursor_col, output cursor_row,
                    output cursor_pos, output cell_data, output scrolled,
                    input ready);
    modport sink   (input valid, input cursor_col, input cursor_row,
                    input cursor_pos, input cell_data, input scrolled,
                    output ready);
endinterface

// File: design/text_console_writer.sv
// Text console writer top level: cell store, cursor and sweep sequencer.
// Depends on tcw_pkg, tcw_cmd_if and tcw_rsp_if.
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+---------------------------------------------
//   cmd     | in  | valid/ready   | op, char_code, cell_index
//   rsp     | out | valid/ready   | cursor_col, cursor_row, cursor_pos,
//           |     |               | cell_data, scrolled
//   cfg     | in  | cfg_we        | cfg_index, cfg_data (fg / bg color)
//
// Cycles per command: put 2, read 1, op 3 1; clear COLUMNS*ROWS+1; a put that
// scrolls adds COLUMNS*ROWS+1, set by the cell-by-cell walk through the store
// (one read and one write per cycle, copy pipelined one cell deep).
// Reset: after rst_n releases, a clearing pass of COLUMNS*ROWS cycles fills the
// store with blanks in attribute 0x0B; cmd.ready stays low meanwhile.
// Stalls: a new command is taken while a response still waits; its response
// waits in the done state until the response register frees up.
`timescale 1ns / 1ps

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                             clk,
    input  logic                             rst_n,
    tcw_cmd_if.sink                          cmd,
    tcw_rsp_if.source                        rsp,
    input  logic                             cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int LAST_COPY = CELLS - COLUMNS;   // first cell of the bottom row

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [tcw_pkg::COLOR_W-1:0] fg_reg;
    logic [tcw_pkg::COLOR_W-1:0] bg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= tcw_pkg::FG_RESET;
            bg_reg <= tcw_pkg::BG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tcw_pkg::CFG_FG_COLOR: fg_reg <= cfg_data;
                tcw_pkg::CFG_BG_COLOR: bg_reg <= cfg_data;
            endcase
        end
    end

    logic [tcw_pkg::ATTR_W-1:0] attr;
    logic [tcw_pkg::CELL_W-1:0] blank_cell;
    assign attr       = {bg_reg, fg_reg};
    assign blank_cell = {attr, tcw_pkg::CH_BLANK};

    // ------------------------------------------------------------------
    // Cell store: one write and one registered read per cycle
    // ------------------------------------------------------------------
    logic [tcw_pkg::CELL_W-1:0] cell_mem [0:CELLS-1];
    logic [tcw_pkg::CELL_W-1:0] rd_data_reg;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [tcw_pkg::CELL_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [ADDR_W-1:0]          mem_raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= cell_mem[mem_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and cursor state
    // ------------------------------------------------------------------
    tcw_pkg::state_t             state_reg, state_next;
    logic [ADDR_W-1:0]           cnt_reg, cnt_next;        // sweep pointer
    logic [COL_W-1:0]            col_reg, col_next;
    logic [ROW_W-1:0]            row_reg, row_next;
    logic [ADDR_W-1:0]           pos_reg, pos_next;        // row*COLUMNS + col
    logic                        wb_valid_reg, wb_valid_next;
    logic [ADDR_W-1:0]           wb_addr_reg, wb_addr_next;
    logic                        scrolled_reg, scrolled_next;
    logic                        data_ok_reg, data_ok_next;
    logic [tcw_pkg::CHAR_W-1:0]  char_reg, char_next;

    // response register
    logic                           rsp_valid_reg, rsp_valid_next;
    logic [tcw_pkg::COL_OUT_W-1:0]  rsp_col_reg, rsp_col_next;
    logic [tcw_pkg::ROW_OUT_W-1:0]  rsp_row_reg, rsp_row_next;
    logic [tcw_pkg::POS_OUT_W-1:0]  rsp_pos_reg, rsp_pos_next;
    logic [tcw_pkg::CELL_W-1:0]     rsp_data_reg, rsp_data_next;
    logic                           rsp_scr_reg, rsp_scr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcw_pkg::ST_INIT;
            cnt_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            pos_reg       <= '0;
            wb_valid_reg  <= 1'b0;
            scrolled_reg  <= 1'b0;
            data_ok_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            pos_reg       <= pos_next;
            wb_valid_reg  <= wb_valid_next;
            scrolled_reg  <= scrolled_next;
            data_ok_reg   <= data_ok_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        wb_addr_reg  <= wb_addr_next;
        char_reg     <= char_next;
        rsp_col_reg  <= rsp_col_next;
        rsp_row_reg  <= rsp_row_next;
        rsp_pos_reg  <= rsp_pos_next;
        rsp_data_reg <= rsp_data_next;
        rsp_scr_reg  <= rsp_scr_next;
    end

    // ------------------------------------------------------------------
    // Put: cursor step for one byte (used in ST_PUT)
    // ------------------------------------------------------------------
    logic [COL_W:0]    col_ext;
    logic [COL_W:0]    step_col;      // column before the wrap check
    logic [COL_W:0]    new_col;
    logic              row_inc;
    logic              put_scroll;
    logic              put_we;
    logic [ADDR_W-1:0] put_addr;
    logic [tcw_pkg::CELL_W-1:0] put_data;
    logic [ADDR_W-1:0] row_base;
    logic [ADDR_W-1:0] put_pos;

    always_comb
    begin
        col_ext  = {1'b0, col_reg};
        step_col = col_ext;
        row_inc  = 1'b0;
        put_we   = 1'b0;
        put_addr = pos_reg;
        put_data = {attr, char_reg};
        priority if (char_reg == tcw_pkg::CH_LF)
        begin
            step_col = '0;
            row_inc  = 1'b1;
        end
        else if (char_reg == tcw_pkg::CH_CR)
        begin
            step_col = '0;
        end
        else if (char_reg == tcw_pkg::CH_BS)
        begin
            // at column zero nothing happens
            if (col_reg != '0)
            begin
                step_col = col_ext - 1'b1;
                put_we   = 1'b1;
                put_addr = pos_reg - 1'b1;
                put_data = blank_cell;
            end
        end
        else if (char_reg == tcw_pkg::CH_TAB)
        begin
            step_col = (col_ext + (COL_W+1)'(8)) & ~(COL_W+1)'(7);
        end
        else
        begin
            step_col = col_ext + 1'b1;
            put_we   = 1'b1;
        end

        new_col = step_col;
        if (step_col >= (COL_W+1)'(COLUMNS))
        begin
            new_col = '0;
            row_inc = 1'b1;
        end

        // bottom row overflow: the row stays, the store scrolls instead
        put_scroll = row_inc && (row_reg == ROW_W'(ROWS - 1));
        row_base   = pos_reg - ADDR_W'(col_reg);
        put_pos    = row_base + ADDR_W'(new_col)
                   + ((row_inc && !put_scroll) ? ADDR_W'(COLUMNS) : '0);
    end

    // ------------------------------------------------------------------
    // Output width fitting (zero-extend or mask)
    // ------------------------------------------------------------------
    logic [31:0] col_wide, row_wide, pos_wide, idx_wide;
    assign col_wide = 32'(col_reg);
    assign row_wide = 32'(row_reg);
    assign pos_wide = 32'(pos_reg);
    assign idx_wide = 32'(cmd.cell_index);

    // ------------------------------------------------------------------
    // Next state and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        pos_next       = pos_reg;
        wb_valid_next  = 1'b0;
        wb_addr_next   = wb_addr_reg;
        scrolled_next  = scrolled_reg;
        data_ok_next   = data_ok_reg;
        char_next      = char_reg;
        mem_we         = 1'b0;
        mem_waddr      = cnt_reg;
        mem_wdata      = blank_cell;
        mem_re         = 1'b0;
        mem_raddr      = idx_wide[ADDR_W-1:0];
        cmd.ready      = 1'b0;

        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_col_next   = rsp_col_reg;
        rsp_row_next   = rsp_row_reg;
        rsp_pos_next   = rsp_pos_reg;
        rsp_data_next  = rsp_data_reg;
        rsp_scr_next   = rsp_scr_reg;

        unique case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                // power-up clearing pass in the reset attribute
                mem_we    = 1'b1;
                mem_wdata = tcw_pkg::RESET_BLANK;
                if (cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            tcw_pkg::ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    scrolled_next = 1'b0;
                    data_ok_next  = 1'b0;
                    char_next     = cmd.char_code;
                    unique case (cmd.op)
                        tcw_pkg::OP_PUT:
                        begin
                            state_next = tcw_pkg::ST_PUT;
                        end
                        tcw_pkg::OP_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            pos_next   = '0;
                            cnt_next   = '0;
                            state_next = tcw_pkg::ST_FILL;
                        end
                        tcw_pkg::OP_READ:
                        begin
                            mem_re       = 1'b1;
                            data_ok_next = (idx_wide < CELLS);
                            state_next   = tcw_pkg::ST_DONE;
                        end
                        default:
                        begin
                            state_next = tcw_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            tcw_pkg::ST_PUT:
            begin
                mem_we    = put_we;
                mem_waddr = put_addr;
                mem_wdata = put_data;
                col_next  = new_col[COL_W-1:0];
                row_next  = (row_inc && !put_scroll) ? row_reg + 1'b1 : row_reg;
                pos_next  = put_pos;
                if (put_scroll)
                begin
                    scrolled_next = 1'b1;
                    cnt_next      = '0;
                    state_next    = tcw_pkg::ST_SCROLL;
                end
                else
                begin
                    state_next = tcw_pkg::ST_DONE;
                end
            end

            tcw_pkg::ST_SCROLL:
            begin
                // read cell cnt+COLUMNS now, write it to cnt next cycle
                mem_we    = wb_valid_reg;
                mem_waddr = wb_addr_reg;
                mem_wdata = rd_data_reg;
                if (cnt_reg < ADDR_W'(LAST_COPY))
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = cnt_reg + ADDR_W'(COLUMNS);
                    wb_valid_next = 1'b1;
                    wb_addr_next  = cnt_reg;
                    cnt_next      = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = tcw_pkg::ST_FILL;   // blank the bottom row
                end
            end

            tcw_pkg::ST_FILL:
            begin
                mem_we = 1'b1;
                if (cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = tcw_pkg::ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            tcw_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_col_next   = col_wide[tcw_pkg::COL_OUT_W-1:0];
                    rsp_row_next   = row_wide[tcw_pkg::ROW_OUT_W-1:0];
                    rsp_pos_next   = pos_wide[tcw_pkg::POS_OUT_W-1:0];
                    rsp_data_next  = data_ok_reg ? rd_data_reg : '0;
                    rsp_scr_next   = scrolled_reg;
                    state_next     = tcw_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.cursor_col = rsp_col_reg;
    assign rsp.cursor_row = rsp_row_reg;
    assign rsp.cursor_pos = rsp_pos_reg;
    assign rsp.cell_data  = rsp_data_reg;
    assign rsp.scrolled   = rsp_scr_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // cursor stays on screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(col_reg) < COLUMNS) && (32'(row_reg) < ROWS))
        else $error("cursor off screen");

    // linear position tracks row and column between commands
    a_pos_track: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcw_pkg::ST_IDLE) |->
            (32'(pos_reg) == 32'(row_reg) * COLUMNS + 32'(col_reg)))
        else $error("cursor position out of step with row/column");

    // a scroll always leaves the cursor at the start of a line
    a_scroll_col: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.scrolled) |-> (rsp.cursor_col == '0))
        else $error("scroll with nonzero column");

    // no store writes while waiting for a command
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready |-> !mem_we)
        else $error("store written while idle");

endmodule
